// ===== rtl/pwmdfs_pkg.sv =====
// shared types and constants for the pwm divider factor search
// no dependencies; imported by the top level and its checker
package pwmdfs_pkg;

    localparam int COUNTER_MAX_DEF = 65535;

    localparam int RATIO_W = 32;
    localparam int DUTY_W  = 20;
    localparam int PHASE_W = 32;
    localparam int IN_W    = 88;

    localparam int PSC_W   = 16;
    localparam int ARR_W   = 16;
    localparam int CMP_W   = 20;
    localparam int START_W = 16;
    localparam int ERR_W   = 32;
    localparam int OUT_W   = 104;

    localparam int DUTY_SCALE = 100000;
    localparam int ROUND_HALF = 50000;

    localparam logic [ERR_W-1:0] ERR_NONE = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_SEARCH,
        ST_MUL,
        ST_DIV_CMP,
        ST_DIV_START,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/pwm_divider_factor_search.sv =====
// pwm divider factor search: prescaler/reload pair, compare and start count
// uses pwmdfs_pkg; one bit-serial restoring divider shared by three divides
//
//  channel | dir | handshake          | word
//  s_*     | in  | s_tvalid/s_tready  | ratio, duty, phase
//  m_*     | out | m_tvalid/m_tready  | prescaler, reload, compare, start, error
//
// a word runs the first divide, the reload search, the duty multiply and two
// more divides; divides are DW bits, the multiply CW; DW = 37 and CW = 16 at default
// the search steps one reload factor a cycle and ends at an exact match, once
// the quotient reaches the reload or at reload factor 2, at most COUNTER_MAX - 1 steps
// s_tready is high only while idle; a finished word waits in the output register
// while the next word is taken; rst_n clears state and the output valid
module pwm_divider_factor_search
    import pwmdfs_pkg::*;
#(
    parameter int COUNTER_MAX = COUNTER_MAX_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // division_ratio[31:0], duty_milli_percent[51:32], phase_ticks[83:52]
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // prescaler_value[15:0], reload_value[31:16], compare_value[51:32],
    // start_count[67:52], match_error[99:68]
    output logic [OUT_W-1:0] m_tdata
);

    localparam int CW   = $clog2(COUNTER_MAX + 1);
    localparam int DW   = (CW + 21 > RATIO_W) ? CW + 21 : RATIO_W;
    localparam int DVW  = (CW > 17) ? CW : 17;
    localparam int CNTW = $clog2(DW);

    state_t state_reg, state_next;

    logic [DW-1:0]      div_acc_reg, div_acc_next;
    logic [DVW-1:0]     div_rem_reg, div_rem_next;
    logic [DVW-1:0]     div_dvs_reg, div_dvs_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CW-1:0]      r_reg, r_next;
    logic [CW:0]        q_reg, q_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic               found_reg, found_next;
    logic [CW-1:0]      best_reg, best_next;
    logic [CW-1:0]      psc_reg, psc_next;
    logic [CW-1:0]      arr_reg, arr_next;
    logic [CW-1:0]      mplier_reg, mplier_next;
    logic [CMP_W-1:0]   cmp_reg, cmp_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    // divider step
    logic [DVW:0]       trial;
    logic               trial_ge;
    logic               div_last;
    logic               mul_last;

    // search step
    logic               q_ge_r;
    logic               cand;
    logic               better;
    logic               exact;
    logic               r_last;
    logic               search_stop;
    logic               init_none;
    logic [CW-1:0]      rm1;
    logic [CW:0]        step_sum;
    logic [CW:0]        rm1_x2;
    logic               out_free;

    assign trial    = {div_rem_reg, div_acc_reg[DW-1]};
    assign trial_ge = trial >= {1'b0, div_dvs_reg};
    assign div_last = cnt_reg == CNTW'(DW - 1);
    assign mul_last = cnt_reg == CNTW'(CW - 1);

    assign q_ge_r      = q_reg >= {1'b0, r_reg};
    assign cand        = !q_ge_r && (q_reg != '0);
    assign better      = cand && (!found_reg || (rem_reg < best_reg));
    assign exact       = better && (rem_reg == '0);
    assign r_last      = r_reg == CW'(2);
    assign search_stop = q_ge_r || exact || r_last;
    assign init_none   = {div_acc_reg[DW-2:0], trial_ge} >= DW'(COUNTER_MAX);
    assign rm1         = r_reg - CW'(1);
    assign step_sum    = {1'b0, rem_reg} + q_reg;
    assign rm1_x2      = {rm1, 1'b0};
    assign out_free    = !m_tvalid_reg || m_tready;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                if (div_last)
                    state_next = init_none ? ST_MUL : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (search_stop)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_last)
                    state_next = ST_DIV_CMP;
            end
            ST_DIV_CMP:
            begin
                if (div_last)
                    state_next = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                if (div_last)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        div_acc_next  = {div_acc_reg[DW-2:0], trial_ge};
        div_rem_next  = trial_ge ? DVW'(trial - {1'b0, div_dvs_reg}) : trial[DVW-1:0];
        div_dvs_next  = div_dvs_reg;
        cnt_next      = cnt_reg + CNTW'(1);
        duty_next     = duty_reg;
        phase_next    = phase_reg;
        r_next        = r_reg;
        q_next        = q_reg;
        rem_next      = rem_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        psc_next      = psc_reg;
        arr_next      = arr_reg;
        mplier_next   = mplier_reg;
        cmp_next      = cmp_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                div_acc_next = DW'(s_tdata[RATIO_W-1:0]);
                div_rem_next = '0;
                div_dvs_next = DVW'(COUNTER_MAX);
                cnt_next     = '0;
                duty_next    = s_tdata[RATIO_W +: DUTY_W];
                phase_next   = s_tdata[RATIO_W + DUTY_W +: PHASE_W];
                found_next   = 1'b0;
                best_next    = '0;
                psc_next     = '0;
                arr_next     = CW'(1);
            end
            ST_DIV_INIT:
            begin
                if (div_last)
                begin
                    r_next      = CW'(COUNTER_MAX);
                    q_next      = div_acc_next[CW:0];
                    rem_next    = div_rem_next[CW-1:0];
                    mplier_next = CW'(2);
                    if (init_none)
                    begin
                        div_acc_next = '0;
                        cnt_next     = '0;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (better)
                begin
                    found_next = 1'b1;
                    best_next  = rem_reg;
                    psc_next   = q_reg[CW-1:0] - CW'(1);
                    arr_next   = rm1;
                end
                mplier_next  = better ? r_reg : arr_reg + CW'(1);
                div_acc_next = '0;
                cnt_next     = '0;
                r_next       = rm1;
                if (step_sum >= rm1_x2)
                begin
                    q_next   = q_reg + (CW+1)'(2);
                    rem_next = CW'(step_sum - rm1_x2);
                end
                else if (step_sum >= {1'b0, rm1})
                begin
                    q_next   = q_reg + (CW+1)'(1);
                    rem_next = CW'(step_sum - {1'b0, rm1});
                end
                else
                begin
                    rem_next = step_sum[CW-1:0];
                end
            end
            ST_MUL:
            begin
                div_acc_next = {div_acc_reg[DW-2:0], 1'b0}
                             + (mplier_reg[CW-1] ? DW'(duty_reg) : DW'(0));
                mplier_next  = {mplier_reg[CW-2:0], 1'b0};
                if (mul_last)
                begin
                    div_acc_next = div_acc_next + DW'(ROUND_HALF);
                    div_rem_next = '0;
                    div_dvs_next = DVW'(DUTY_SCALE);
                    cnt_next     = '0;
                end
            end
            ST_DIV_CMP:
            begin
                if (div_last)
                begin
                    cmp_next     = div_acc_next[CMP_W-1:0];
                    div_acc_next = DW'(phase_reg);
                    div_rem_next = '0;
                    div_dvs_next = DVW'(psc_reg) + DVW'(1);
                    cnt_next     = '0;
                end
            end
            ST_DIV_START:
            begin
                cnt_next = div_last ? '0 : cnt_reg + CNTW'(1);
            end
            ST_OUT:
            begin
                div_acc_next = div_acc_reg;
                div_rem_next = div_rem_reg;
                cnt_next     = cnt_reg;
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0,
                                     found_reg ? ERR_W'(best_reg) : ERR_NONE,
                                     div_acc_reg[START_W-1:0],
                                     cmp_reg,
                                     ARR_W'(arr_reg),
                                     PSC_W'(psc_reg)};
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_acc_reg <= div_acc_next;
        div_rem_reg <= div_rem_next;
        div_dvs_reg <= div_dvs_next;
        cnt_reg     <= cnt_next;
        duty_reg    <= duty_next;
        phase_reg   <= phase_next;
        r_reg       <= r_next;
        q_reg       <= q_next;
        rem_reg     <= rem_next;
        found_reg   <= found_next;
        best_reg    <= best_next;
        psc_reg     <= psc_next;
        arr_reg     <= arr_next;
        mplier_reg  <= mplier_next;
        cmp_reg     <= cmp_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== rtl/pwmdfs_chk.sv =====
// port-level checks for the pwm divider factor search
// uses pwmdfs_pkg; bound to pwm_divider_factor_search below
module pwmdfs_chk
    import pwmdfs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // prescaler register always below reload register
    a_psc_lt_arr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[15:0] < m_tdata[31:16])
        else $error("prescaler not below reload");

    // no pair found gives the fixed fallback registers
    a_none_regs: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[99:68] == ERR_NONE)
        |-> (m_tdata[15:0] == 16'd0) && (m_tdata[31:16] == 16'd1))
        else $error("fallback registers wrong when no pair found");

    // a taken word leaves the block busy, with the input not ready
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a word was taken");

endmodule

bind pwm_divider_factor_search pwmdfs_chk u_pwmdfs_chk (.*);
